// ===== rtl/ssfd_pkg.sv =====
// shared types, constants and the sync phase transition function of the deframer
package ssfd_pkg;

   localparam logic [7:0] SYNC_A       = 8'h7f;
   localparam logic [7:0] SYNC_B       = 8'h7e;
   localparam logic [7:0] REQ_SUPPRESS = 8'hff;
   localparam logic [8:0] COUNT_MAX    = 9'd511;
   localparam logic [8:0] HDR_BYTES    = 9'd5;
   localparam logic [8:0] FIRST_DATA   = 9'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_A1    = 4'd1,
      PH_B1    = 4'd2,
      PH_A2    = 4'd3,
      PH_DATA  = 4'd4,
      PH_D1    = 4'd5,
      PH_D2    = 4'd6,
      PH_D3    = 4'd7,
      PH_SYNC  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] src_addr;
      logic [7:0] dst_addr;
      logic [7:0] request_code;
      logic [7:0] ack_code;
      logic [7:0] payload_length;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       last;
      logic       aborted;
   } rsp_type;

   function automatic phase_type next_phase(input phase_type p, input logic [7:0] b);
      phase_type n;
      n = PH_HUNT;
      if (b == SYNC_A) begin
         unique case (p)
            PH_HUNT: n = PH_A1;
            PH_A1:   n = PH_B1;
            PH_B1:   n = PH_A2;
            PH_A2:   n = PH_SYNC;
            PH_DATA: n = PH_D1;
            PH_D1:   n = PH_D2;
            PH_D2:   n = PH_D3;
            PH_D3:   n = PH_SYNC;
            PH_SYNC: n = PH_DATA;
            default: n = PH_HUNT;
         endcase
      end else if (b == SYNC_B) begin
         unique case (p)
            PH_HUNT: n = PH_HUNT;
            PH_A1:   n = PH_B1;
            PH_B1:   n = PH_B1;
            PH_A2:   n = PH_SYNC;
            PH_DATA: n = PH_DATA;
            PH_D1:   n = PH_D2;
            PH_D2:   n = PH_DATA;
            PH_D3:   n = PH_SYNC;
            PH_SYNC: n = PH_DATA;
            default: n = PH_HUNT;
         endcase
      end else begin
         unique case (p)
            PH_HUNT: n = PH_HUNT;
            PH_A1:   n = PH_A1;
            PH_B1:   n = PH_B1;
            PH_A2:   n = PH_A2;
            PH_DATA: n = PH_DATA;
            PH_D1:   n = PH_DATA;
            PH_D2:   n = PH_DATA;
            PH_D3:   n = PH_DATA;
            PH_SYNC: n = PH_DATA;
            default: n = PH_HUNT;
         endcase
      end
      return n;
   endfunction

endpackage

// ===== rtl/ssfd_front.sv =====
// front end: sync hunt, header capture and request classification
module ssfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output logic             rsp_valid,
   output ssfd_pkg::rsp_type rsp
);

   ssfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] src_ff, src_in;
   logic [7:0] dst_ff, dst_in;
   logic [7:0] req_ff, req_in;
   logic [7:0] ack_ff, ack_in;
   logic [7:0] len_ff, len_in;
   logic [8:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;
   logic       open_ff, open_in;

   logic       enter_sync;
   logic [8:0] last_cnt;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         phase_in = ssfd_pkg::next_phase(phase_ff, rx_byte);
      end
   end

   assign enter_sync = (phase_in == ssfd_pkg::PH_SYNC) && (phase_ff != ssfd_pkg::PH_SYNC);

   // frame bookkeeping and result
   always_comb begin
      src_in    = src_ff;
      dst_in    = dst_ff;
      req_in    = req_ff;
      ack_in    = ack_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      open_in   = open_ff;
      rsp_valid = 1'b0;
      last_cnt  = 9'd0;
      rsp.src_addr       = src_ff;
      rsp.dst_addr       = dst_ff;
      rsp.request_code   = req_ff;
      rsp.ack_code       = ack_ff;
      rsp.payload_length = len_ff;
      rsp.data_byte      = 8'd0;
      rsp.byte_index     = 8'd0;
      rsp.last           = 1'b0;
      rsp.aborted        = 1'b0;
      if (byte_valid && enter_sync) begin
         if (open_ff) begin
            rsp_valid   = 1'b1;
            rsp.last    = 1'b1;
            rsp.aborted = 1'b1;
         end
         len_in  = 8'd0;
         cnt_in  = 9'd0;
         fin_in  = 1'b0;
         open_in = 1'b0;
      end else if (byte_valid && (phase_in == ssfd_pkg::PH_DATA)) begin
         if (cnt_ff < ssfd_pkg::COUNT_MAX) begin
            cnt_in = cnt_ff + 9'd1;
         end
         last_cnt = {1'b0, len_ff} + ssfd_pkg::HDR_BYTES;
         case (cnt_in)
            9'd1: src_in = rx_byte;
            9'd2: dst_in = rx_byte;
            9'd3: req_in = rx_byte;
            9'd4: ack_in = rx_byte;
            9'd5: len_in = rx_byte;
            default: begin
               if (!fin_ff && (cnt_in <= last_cnt)) begin
                  if (req_ff == ssfd_pkg::REQ_SUPPRESS) begin
                     fin_in = 1'b1;
                  end else begin
                     rsp_valid      = 1'b1;
                     rsp.data_byte  = rx_byte;
                     rsp.byte_index = 8'(cnt_in - ssfd_pkg::FIRST_DATA);
                     rsp.last       = (cnt_in == last_cnt);
                     if (cnt_in == last_cnt) begin
                        fin_in  = 1'b1;
                        open_in = 1'b0;
                     end else begin
                        open_in = 1'b1;
                     end
                  end
               end else if (req_ff == ssfd_pkg::REQ_SUPPRESS) begin
                  fin_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssfd_pkg::PH_HUNT;
         src_ff   <= 8'd0;
         dst_ff   <= 8'd0;
         req_ff   <= 8'd0;
         ack_ff   <= 8'd0;
         len_ff   <= 8'd0;
         cnt_ff   <= 9'd0;
         fin_ff   <= 1'b0;
         open_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         req_ff   <= req_in;
         ack_ff   <= ack_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         open_ff  <= open_in;
      end
   end

endmodule

// ===== rtl/ssfd_queue.sv =====
// back end: short result queue between the classifier and the response port
module ssfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  ssfd_pkg::rsp_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             empty,
   output ssfd_pkg::rsp_type rd_data
);

   ssfd_pkg::rsp_type entry_ff [ssfd_pkg::QUEUE_DEPTH];
   logic [ssfd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssfd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssfd_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_wr;
   logic do_rd;

   assign full    = (count_ff == ssfd_pkg::QUEUE_CW'(ssfd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == ssfd_pkg::QUEUE_AW'(ssfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ssfd_pkg::QUEUE_AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == ssfd_pkg::QUEUE_AW'(ssfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ssfd_pkg::QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + ssfd_pkg::QUEUE_CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - ssfd_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/serial_sync_frame_deframer_unit.sv =====
// top level of the serial sync frame deframer
//
// Request side: one received serial byte per request on req_rx_byte, taken at a
// clock edge with push high and full low. Bytes are scanned for the sync
// sequence 7f, 7e|7f, 7f, 7e|7f; the next five bytes form the header and up to
// payload_length payload bytes follow, tagged with it; request code ff drops them.
// Response side: the oldest result sits on the rsp_ ports while empty is low and
// is taken at an edge with pop high. A request gives zero or one result; aborted
// marks a frame cut by a new sync.
// A result is queued at the edge that takes its request, behind older results.
// Throughput: one request per cycle while full is low, as the front end updates
// its phase and header state for each request; the four-entry result queue lets
// requests continue while the receiver pauses.
// When the receiver stalls the queue fills and full rises, holding off requests
// until pop frees an entry.
// Reset: synchronous; returns to hunting, clears the header and empties the queue.
module serial_sync_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_src_addr,
   output logic [7:0] rsp_dst_addr,
   output logic [7:0] rsp_request_code,
   output logic [7:0] rsp_ack_code,
   output logic [7:0] rsp_payload_length,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic       rsp_last,
   output logic       rsp_aborted
);

   logic             byte_valid;
   logic             front_valid;
   ssfd_pkg::rsp_type front_rsp;
   ssfd_pkg::rsp_type head_rsp;

   assign byte_valid = push && !full;

   ssfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .rsp_valid  (front_valid),
      .rsp        (front_rsp)
   );

   ssfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_rsp),
      .full    (full),
      .rd_en   (pop),
      .empty   (empty),
      .rd_data (head_rsp)
   );

   assign rsp_src_addr       = head_rsp.src_addr;
   assign rsp_dst_addr       = head_rsp.dst_addr;
   assign rsp_request_code   = head_rsp.request_code;
   assign rsp_ack_code       = head_rsp.ack_code;
   assign rsp_payload_length = head_rsp.payload_length;
   assign rsp_data_byte      = head_rsp.data_byte;
   assign rsp_byte_index     = head_rsp.byte_index;
   assign rsp_last           = head_rsp.last;
   assign rsp_aborted        = head_rsp.aborted;

endmodule
